// ----- rtl/si_pkg.sv -----
// Shared constants for the segment intersection block.
package si_pkg;

  // Fraction bits of the input coordinates (Q.4).
  localparam int IN_FRAC_BITS = 4;
  // Width of the bound tolerance register.
  localparam int TOL_BITS = 8;
  // Reset value of the bound tolerance register.
  localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd1;

endpackage

// ----- rtl/si_front.sv -----
// Front pipeline: endpoint match, bound ranges, determinant, numerators, divider operands and quotient range check.
module si_front import si_pkg::*; #(
  parameter int CB = 16,
  parameter int SH = 4,
  localparam int DIFW = CB + 1,
  localparam int PW = 2 * DIFW,
  localparam int DW = PW + 1,
  localparam int MW = DW + DIFW,
  localparam int SNW = MW + 1 + SH,
  localparam int QB = CB + SH + 1,
  localparam int RW = ((SNW + 2) > (DW + 1 + QB) ? (SNW + 2) : (DW + 1 + QB)) + 1,
  localparam int BW = CB + SH + 2,
  localparam int SDW = 1 + 2 * CB + 4 * BW,
  localparam int SW = 5 + SDW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [CB-1:0] ax1,
  input  logic signed [CB-1:0] ay1,
  input  logic signed [CB-1:0] ax2,
  input  logic signed [CB-1:0] ay2,
  input  logic signed [CB-1:0] bx1,
  input  logic signed [CB-1:0] by1,
  input  logic signed [CB-1:0] bx2,
  input  logic signed [CB-1:0] by2,
  input  logic [TOL_BITS-1:0]  tol,
  output logic                 out_v,
  output logic [RW-1:0]        out_nx,
  output logic [RW-1:0]        out_ny,
  output logic [RW-1:0]        out_d,
  output logic [SW-1:0]        out_side
);

  // ---------------- stage 1: differences, shared endpoint, bound ranges
  logic                   m_start, m_end;
  logic signed [CB-1:0]   loax, hiax, lobx, hibx, loay, hiay, loby, hiby;
  logic                   v1_r, shr1_r;
  logic signed [CB-1:0]   px1_r, py1_r, xlo1_r, xhi1_r, ylo1_r, yhi1_r;
  logic signed [CB-1:0]   ax1_1_r, ay1_1_r;
  logic signed [DIFW-1:0] dax1_r, day1_r, dbx1_r, dby1_r, ex1_r, ey1_r;

  always_comb begin
    m_start = ((ax1 == bx1) && (ay1 == by1)) || ((ax1 == bx2) && (ay1 == by2));
    m_end   = ((ax2 == bx1) && (ay2 == by1)) || ((ax2 == bx2) && (ay2 == by2));
    loax = (ax1 < ax2) ? ax1 : ax2;
    hiax = (ax1 < ax2) ? ax2 : ax1;
    lobx = (bx1 < bx2) ? bx1 : bx2;
    hibx = (bx1 < bx2) ? bx2 : bx1;
    loay = (ay1 < ay2) ? ay1 : ay2;
    hiay = (ay1 < ay2) ? ay2 : ay1;
    loby = (by1 < by2) ? by1 : by2;
    hiby = (by1 < by2) ? by2 : by1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shr1_r  <= m_start | m_end;
      px1_r   <= m_start ? ax1 : ax2;
      py1_r   <= m_start ? ay1 : ay2;
      // both ranges must hold, so keep their overlap
      xlo1_r  <= (loax > lobx) ? loax : lobx;
      xhi1_r  <= (hiax < hibx) ? hiax : hibx;
      ylo1_r  <= (loay > loby) ? loay : loby;
      yhi1_r  <= (hiay < hiby) ? hiay : hiby;
      ax1_1_r <= ax1;
      ay1_1_r <= ay1;
      dax1_r  <= DIFW'(ax1) - DIFW'(ax2);
      day1_r  <= DIFW'(ay1) - DIFW'(ay2);
      dbx1_r  <= DIFW'(bx1) - DIFW'(bx2);
      dby1_r  <= DIFW'(by1) - DIFW'(by2);
      ex1_r   <= DIFW'(ax1) - DIFW'(bx1);
      ey1_r   <= DIFW'(ay1) - DIFW'(by1);
    end
  end

  // ---------------- stage 2: cross products, scaled bounds
  logic signed [BW-1:0]   tol_s;
  logic                   v2_r;
  logic [SDW-1:0]         sd2_r;
  logic signed [CB-1:0]   ax1_2_r, ay1_2_r;
  logic signed [DIFW-1:0] dax2_r, day2_r;
  logic signed [PW-1:0]   p1_r, p2_r, p3_r, p4_r;
  logic signed [BW-1:0]   xlo_s, xhi_s, ylo_s, yhi_s;

  always_comb begin
    tol_s = BW'($signed({1'b0, tol}));
    xlo_s = (BW'(xlo1_r) <<< SH) - tol_s;
    xhi_s = (BW'(xhi1_r) <<< SH) + tol_s;
    ylo_s = (BW'(ylo1_r) <<< SH) - tol_s;
    yhi_s = (BW'(yhi1_r) <<< SH) + tol_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r   <= {shr1_r, px1_r, py1_r, xlo_s, xhi_s, ylo_s, yhi_s};
      ax1_2_r <= ax1_1_r;
      ay1_2_r <= ay1_1_r;
      dax2_r  <= dax1_r;
      day2_r  <= day1_r;
      p1_r    <= PW'(dax1_r) * PW'(dby1_r);
      p2_r    <= PW'(day1_r) * PW'(dbx1_r);
      p3_r    <= PW'(ex1_r) * PW'(dby1_r);
      p4_r    <= PW'(ey1_r) * PW'(dbx1_r);
    end
  end

  // ---------------- stage 3: determinant and line parameter numerator
  logic                   v3_r;
  logic [SDW-1:0]         sd3_r;
  logic signed [CB-1:0]   ax1_3_r, ay1_3_r;
  logic signed [DIFW-1:0] dax3_r, day3_r;
  logic signed [DW-1:0]   d3_r, tn3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r   <= sd2_r;
      ax1_3_r <= ax1_2_r;
      ay1_3_r <= ay1_2_r;
      dax3_r  <= dax2_r;
      day3_r  <= day2_r;
      d3_r    <= DW'(p1_r) - DW'(p2_r);
      tn3_r   <= DW'(p3_r) - DW'(p4_r);
    end
  end

  // ---------------- stage 4: numerator partial products
  logic                 v4_r;
  logic [SDW-1:0]       sd4_r;
  logic signed [DW-1:0] d4_r;
  logic signed [MW-1:0] m1_r, m2_r, m3_r, m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r <= sd3_r;
      d4_r  <= d3_r;
      m1_r  <= MW'(d3_r) * MW'(ax1_3_r);
      m2_r  <= MW'(tn3_r) * MW'(dax3_r);
      m3_r  <= MW'(d3_r) * MW'(ay1_3_r);
      m4_r  <= MW'(tn3_r) * MW'(day3_r);
    end
  end

  // ---------------- stage 5: numerators, scaled to output fraction
  logic                  v5_r;
  logic [SDW-1:0]        sd5_r;
  logic signed [DW-1:0]  d5_r;
  logic signed [SNW-1:0] nx5_r, ny5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r <= sd4_r;
      d5_r  <= d4_r;
      nx5_r <= (SNW'(m1_r) - SNW'(m2_r)) <<< SH;
      ny5_r <= (SNW'(m3_r) - SNW'(m4_r)) <<< SH;
    end
  end

  // ---------------- stage 6: magnitudes, rounding offset, signs
  logic [SNW-1:0] anx, any;
  logic [DW-1:0]  ad;
  logic           v6_r, negx6_r, negy6_r, dz6_r;
  logic [SDW-1:0] sd6_r;
  logic [RW-1:0]  nx6_r, ny6_r, d6_r;

  always_comb begin
    anx = nx5_r[SNW-1] ? SNW'(-nx5_r) : SNW'(nx5_r);
    any = ny5_r[SNW-1] ? SNW'(-ny5_r) : SNW'(ny5_r);
    ad  = d5_r[DW-1] ? DW'(-d5_r) : DW'(d5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd6_r   <= sd5_r;
      negx6_r <= nx5_r[SNW-1] ^ d5_r[DW-1];
      negy6_r <= ny5_r[SNW-1] ^ d5_r[DW-1];
      dz6_r   <= (d5_r == '0);
      // round to nearest, ties away: (2|n| + |d|) / (2|d|)
      nx6_r   <= (RW'(anx) << 1) + RW'(ad);
      ny6_r   <= (RW'(any) << 1) + RW'(ad);
      d6_r    <= RW'(ad) << 1;
    end
  end

  // ---------------- stage 7: quotient range check
  logic          v7_r;
  logic [SW-1:0] side7_r;
  logic [RW-1:0] nx7_r, ny7_r, d7_r;
  logic [RW-1:0] dlim;

  assign dlim = d6_r << QB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // a quotient this large can never pass the bounds test
      side7_r <= {nx6_r >= dlim, ny6_r >= dlim, negx6_r, negy6_r, dz6_r, sd6_r};
      nx7_r   <= nx6_r;
      ny7_r   <= ny6_r;
      d7_r    <= d6_r;
    end
  end

  assign out_v    = v7_r;
  assign out_nx   = nx7_r;
  assign out_ny   = ny7_r;
  assign out_d    = d7_r;
  assign out_side = side7_r;

endmodule

// ----- rtl/si_div_cell.sv -----
// One restoring-division cell: resolves one quotient bit for both coordinates.
module si_div_cell #(
  parameter int RW = 60,
  parameter int QB = 21,
  parameter int K = 0,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [RW-1:0] in_rx,
  input  logic [RW-1:0] in_ry,
  input  logic [RW-1:0] in_d,
  input  logic [QB-1:0] in_qx,
  input  logic [QB-1:0] in_qy,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [RW-1:0] out_rx,
  output logic [RW-1:0] out_ry,
  output logic [RW-1:0] out_d,
  output logic [QB-1:0] out_qx,
  output logic [QB-1:0] out_qy,
  output logic [SW-1:0] out_side
);

  logic [RW-1:0] dk;
  logic          gx, gy;
  logic          v_r;
  logic [RW-1:0] rx_r, ry_r, d_r;
  logic [QB-1:0] qx_r, qy_r;
  logic [SW-1:0] side_r;

  always_comb begin
    dk = in_d << K;
    gx = (in_rx >= dk);
    gy = (in_ry >= dk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= gx ? (in_rx - dk) : in_rx;
      ry_r   <= gy ? (in_ry - dk) : in_ry;
      d_r    <= in_d;
      qx_r   <= {in_qx[QB-2:0], gx};
      qy_r   <= {in_qy[QB-2:0], gy};
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_rx   = rx_r;
  assign out_ry   = ry_r;
  assign out_d    = d_r;
  assign out_qx   = qx_r;
  assign out_qy   = qy_r;
  assign out_side = side_r;

endmodule

// ----- rtl/segment_intersection.sv -----
// Top level of the two-segment intersection block.
// Takes one pair of segments (signed Q12.4 endpoints) per cycle unless the
// output stalls, and returns one transaction per pair: hit, and the crossing
// point in signed Q12.8 (zero without a hit). A shared endpoint is reported as
// is, A's start checked first; parallel or collinear pairs give no hit. The
// crossing is an exact determinant solve and a rounded division (ties away from
// zero), done by a row of restoring division cells, one cell per quotient bit
// (COORD_BITS + OUT_FRAC_BITS - 3 cells, 21 at the defaults). A pair passes 7
// front stages, the cells and 1 output register. A one-entry input skid takes
// one more pair while a result waits at a stalled output; then in_stall rises.
// The user is to write bound_tolerance on cfg_data only while the block is idle;
// the block itself leaves this unenforced. It resets to 1.
module segment_intersection import si_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_start_x,
  input  logic signed [COORD_BITS-1:0] in_a_start_y,
  input  logic signed [COORD_BITS-1:0] in_a_end_x,
  input  logic signed [COORD_BITS-1:0] in_a_end_y,
  input  logic signed [COORD_BITS-1:0] in_b_start_x,
  input  logic signed [COORD_BITS-1:0] in_b_start_y,
  input  logic signed [COORD_BITS-1:0] in_b_end_x,
  input  logic signed [COORD_BITS-1:0] in_b_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_BITS-IN_FRAC_BITS+OUT_FRAC_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-IN_FRAC_BITS+OUT_FRAC_BITS-1:0] out_cross_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [TOL_BITS-1:0]          cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int SH = OUT_FRAC_BITS - IN_FRAC_BITS;
  localparam int OB = CB + SH;
  localparam int DIFW = CB + 1;
  localparam int PW = 2 * DIFW;
  localparam int DW = PW + 1;
  localparam int MW = DW + DIFW;
  localparam int SNW = MW + 1 + SH;
  localparam int QB = CB + SH + 1;
  localparam int RW = ((SNW + 2) > (DW + 1 + QB) ? (SNW + 2) : (DW + 1 + QB)) + 1;
  localparam int BW = CB + SH + 2;
  localparam int SDW = 1 + 2 * CB + 4 * BW;
  localparam int SW = 5 + SDW;

  // ---------------- configuration
  logic [TOL_BITS-1:0] tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // ---------------- input skid and pipeline advance
  logic                 en;
  logic                 skid_full_r;
  logic signed [CB-1:0] sk_ax1_r, sk_ay1_r, sk_ax2_r, sk_ay2_r;
  logic signed [CB-1:0] sk_bx1_r, sk_by1_r, sk_bx2_r, sk_by2_r;
  logic                 src_v;
  logic signed [CB-1:0] s_ax1, s_ay1, s_ax2, s_ay2, s_bx1, s_by1, s_bx2, s_by2;
  logic                 out_valid_r;

  // the whole pipe moves unless a finished result is being held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (en) begin
      skid_full_r <= 1'b0;
    end else if (in_valid && !skid_full_r) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_full_r) begin
      sk_ax1_r <= in_a_start_x;
      sk_ay1_r <= in_a_start_y;
      sk_ax2_r <= in_a_end_x;
      sk_ay2_r <= in_a_end_y;
      sk_bx1_r <= in_b_start_x;
      sk_by1_r <= in_b_start_y;
      sk_bx2_r <= in_b_end_x;
      sk_by2_r <= in_b_end_y;
    end
  end

  always_comb begin
    src_v = skid_full_r | in_valid;
    s_ax1 = skid_full_r ? sk_ax1_r : in_a_start_x;
    s_ay1 = skid_full_r ? sk_ay1_r : in_a_start_y;
    s_ax2 = skid_full_r ? sk_ax2_r : in_a_end_x;
    s_ay2 = skid_full_r ? sk_ay2_r : in_a_end_y;
    s_bx1 = skid_full_r ? sk_bx1_r : in_b_start_x;
    s_by1 = skid_full_r ? sk_by1_r : in_b_start_y;
    s_bx2 = skid_full_r ? sk_bx2_r : in_b_end_x;
    s_by2 = skid_full_r ? sk_by2_r : in_b_end_y;
  end

  // ---------------- front pipeline and division cells
  logic          cv [QB+1];
  logic [RW-1:0] crx [QB+1];
  logic [RW-1:0] cry [QB+1];
  logic [RW-1:0] cd [QB+1];
  logic [QB-1:0] cqx [QB+1];
  logic [QB-1:0] cqy [QB+1];
  logic [SW-1:0] cs [QB+1];

  si_front #(.CB(CB), .SH(SH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (src_v),
    .ax1      (s_ax1),
    .ay1      (s_ay1),
    .ax2      (s_ax2),
    .ay2      (s_ay2),
    .bx1      (s_bx1),
    .by1      (s_by1),
    .bx2      (s_bx2),
    .by2      (s_by2),
    .tol      (tol_r),
    .out_v    (cv[0]),
    .out_nx   (crx[0]),
    .out_ny   (cry[0]),
    .out_d    (cd[0]),
    .out_side (cs[0])
  );

  assign cqx[0] = '0;
  assign cqy[0] = '0;

  for (genvar j = 0; j < QB; j++) begin : g_cell
    si_div_cell #(.RW(RW), .QB(QB), .K(QB - 1 - j), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (cv[j]),
      .in_rx    (crx[j]),
      .in_ry    (cry[j]),
      .in_d     (cd[j]),
      .in_qx    (cqx[j]),
      .in_qy    (cqy[j]),
      .in_side  (cs[j]),
      .out_v    (cv[j+1]),
      .out_rx   (crx[j+1]),
      .out_ry   (cry[j+1]),
      .out_d    (cd[j+1]),
      .out_qx   (cqx[j+1]),
      .out_qy   (cqy[j+1]),
      .out_side (cs[j+1])
    );
  end

  // ---------------- sign, bounds test, saturation
  localparam logic signed [BW-1:0] MAXV = {{(BW-OB+1){1'b0}}, {(OB-1){1'b1}}};
  localparam logic signed [BW-1:0] MINV = ~MAXV;

  logic                 f_ovfx, f_ovfy, f_negx, f_negy, f_dz, f_shr;
  logic signed [CB-1:0] f_px, f_py;
  logic signed [BW-1:0] f_xlo, f_xhi, f_ylo, f_yhi;
  logic signed [BW-1:0] qsx, qsy, satx, saty;
  logic signed [OB-1:0] shx, shy;
  logic                 calc_hit;
  logic                 hit_nxt;
  logic signed [OB-1:0] cx_nxt, cy_nxt;
  logic                 hit_r;
  logic signed [OB-1:0] cx_r, cy_r;

  always_comb begin
    {f_ovfx, f_ovfy, f_negx, f_negy, f_dz, f_shr, f_px, f_py,
     f_xlo, f_xhi, f_ylo, f_yhi} = cs[QB];
    qsx = f_negx ? -$signed({1'b0, cqx[QB]}) : $signed({1'b0, cqx[QB]});
    qsy = f_negy ? -$signed({1'b0, cqy[QB]}) : $signed({1'b0, cqy[QB]});
    calc_hit = !f_dz && !f_ovfx && !f_ovfy &&
               (qsx >= f_xlo) && (qsx <= f_xhi) &&
               (qsy >= f_ylo) && (qsy <= f_yhi);
    satx = (qsx > MAXV) ? MAXV : ((qsx < MINV) ? MINV : qsx);
    saty = (qsy > MAXV) ? MAXV : ((qsy < MINV) ? MINV : qsy);
    shx  = OB'(f_px) <<< SH;
    shy  = OB'(f_py) <<< SH;
    hit_nxt = f_shr | calc_hit;
    if (f_shr) begin
      cx_nxt = shx;
      cy_nxt = shy;
    end else if (calc_hit) begin
      cx_nxt = satx[OB-1:0];
      cy_nxt = saty[OB-1:0];
    end else begin
      cx_nxt = '0;
      cy_nxt = '0;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_cross_x = cx_r;
  assign out_cross_y = cy_r;

endmodule
